// ===== hw/rtl/pwss_pkg.sv =====
// Shared types, codes and defaults for the protein word seed scanner.
package pwss_pkg;

   // Default sizes handed to the top-level parameters
   localparam int INDEX_BITS_DEF    = 15;
   localparam int HIT_DEPTH_DEF     = 65536;
   localparam int MAX_WORD_HITS_DEF = 32;

   // Transaction command codes
   localparam logic [1:0] CMD_WRITE_CELL = 2'd0;
   localparam logic [1:0] CMD_WRITE_HIT  = 2'd1;
   localparam logic [1:0] CMD_RESTART    = 2'd2;
   localparam logic [1:0] CMD_RESIDUE    = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_HIT  = 2'd0;
   localparam logic [1:0] KIND_STOP = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Register indexes and reset values
   localparam logic [1:0] REG_WORD_LEN  = 2'd0;
   localparam logic [1:0] REG_CHAR_BITS = 2'd1;
   localparam logic [1:0] REG_CAPACITY  = 2'd2;
   localparam logic [2:0]  WORD_LEN_RST  = 3'd3;
   localparam logic [3:0]  CHAR_BITS_RST = 4'd5;
   localparam logic [15:0] CAPACITY_RST  = 16'd4096;

   typedef struct packed {
      logic [2:0]  word_len;
      logic [3:0]  char_bits;
      logic [15:0] capacity;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic       clear_wr;
      logic       accept;
      logic       walk_init;
      logic       hit_rd;
      logic       load;
      logic [1:0] kind;
      logic       last;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic residue_go;
      logic clear_done;
      logic word_full;
      logic cnt_zero;
      logic fits;
      logic walk_last;
      logic eos;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/pwss_if.sv =====
// Channel interfaces for the scanner's command input and result output.
interface pwss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] address;
   logic [5:0]  hit_count;
   logic [23:0] data;
   logic [7:0]  residue;
   logic        end_of_sequence;

   modport source (output valid, cmd, address, hit_count, data, residue, end_of_sequence,
                   input ready);
   modport sink   (input valid, cmd, address, hit_count, data, residue, end_of_sequence,
                   output ready);
endinterface

interface pwss_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [23:0] query_offset;
   logic [23:0] subject_offset;
   logic [15:0] total_hits;
   logic        last;

   modport source (output valid, kind, query_offset, subject_offset, total_hits, last,
                   input ready);
   modport sink   (input valid, kind, query_offset, subject_offset, total_hits, last,
                   output ready);
endinterface

// ===== hw/rtl/pwss_csr.sv =====
// APB-style configuration registers of the scanner.
module pwss_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output pwss_pkg::cfg_type cfg
);
   logic [2:0]  word_len_ff;
   logic [3:0]  char_bits_ff;
   logic [15:0] capacity_ff;
   logic [1:0]  reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         word_len_ff  <= pwss_pkg::WORD_LEN_RST;
         char_bits_ff <= pwss_pkg::CHAR_BITS_RST;
         capacity_ff  <= pwss_pkg::CAPACITY_RST;
      end else if (wr_en) begin
         case (reg_idx)
            pwss_pkg::REG_WORD_LEN:  word_len_ff  <= csr_pwdata[2:0];
            pwss_pkg::REG_CHAR_BITS: char_bits_ff <= csr_pwdata[3:0];
            pwss_pkg::REG_CAPACITY:  capacity_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         pwss_pkg::REG_WORD_LEN:  csr_prdata = {29'd0, word_len_ff};
         pwss_pkg::REG_CHAR_BITS: csr_prdata = {28'd0, char_bits_ff};
         pwss_pkg::REG_CAPACITY:  csr_prdata = {16'd0, capacity_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   assign cfg.word_len  = word_len_ff;
   assign cfg.char_bits = char_bits_ff;
   assign cfg.capacity  = capacity_ff;
endmodule

// ===== hw/rtl/pwss_dp.sv =====
// Datapath: word tables, hit memory, rolling index, counters and result register.
module pwss_dp #(
   parameter int INDEX_BITS    = pwss_pkg::INDEX_BITS_DEF,
   parameter int HIT_DEPTH     = pwss_pkg::HIT_DEPTH_DEF,
   parameter int MAX_WORD_HITS = pwss_pkg::MAX_WORD_HITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pwss_pkg::cfg_type        cfg,
   input  pwss_pkg::dp_cmd_type     cmd,
   output pwss_pkg::dp_status_type  status,
   input  logic [1:0]               req_cmd,
   input  logic [15:0]              req_address,
   input  logic [5:0]               req_hit_count,
   input  logic [23:0]              req_data,
   input  logic [7:0]               req_residue,
   input  logic                     req_end_of_sequence,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_kind,
   output logic [23:0]              rsp_query_offset,
   output logic [23:0]              rsp_subject_offset,
   output logic [15:0]              rsp_total_hits,
   output logic                     rsp_last
);
   localparam int HIT_BITS   = $clog2(HIT_DEPTH);
   localparam int CELL_DEPTH = 1 << INDEX_BITS;
   localparam int CNT_BITS   = $clog2(MAX_WORD_HITS + 1);
   localparam int ROLL_BITS  = INDEX_BITS + 8;

   // Memories
   logic [CNT_BITS-1:0] cell_counts [CELL_DEPTH];
   logic [HIT_BITS-1:0] cell_bases  [CELL_DEPTH];
   logic [23:0]         hit_store   [HIT_DEPTH];

   // Scan state
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [2:0]            letters_ff;
   logic [23:0]           pos_ff;
   logic [15:0]           hits_ff;
   logic                  halted_ff;
   logic [CNT_BITS-1:0]   walk_ff;
   logic [INDEX_BITS-1:0] clr_ff;
   logic                  eos_ff;
   logic [CNT_BITS-1:0]   cnt_rd_ff;
   logic [HIT_BITS-1:0]   base_rd_ff;
   logic [23:0]           hit_rd_ff;

   // Result register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [23:0] rsp_query_ff, rsp_subject_ff;
   logic [15:0] rsp_total_ff;
   logic        rsp_last_ff;

   logic [INDEX_BITS+15:0] addr_ext;
   logic [HIT_BITS+15:0]   haddr_ext;
   logic [HIT_BITS+23:0]   data_ext;
   logic [INDEX_BITS-1:0]  cell_addr;
   logic [HIT_BITS-1:0]    hit_wr_addr, hit_rd_addr, base_in;
   logic [5:0]             cnt_sat6;
   logic [CNT_BITS-1:0]    cnt_sat;
   logic [2:0]             wl_eff, wl_m1, back;
   logic [6:0]             word_bits;
   logic [INDEX_BITS-1:0]  idx_mask;
   logic [ROLL_BITS-1:0]   rolled;
   logic [15:0]            room;
   logic [23:0]            start, done_off;
   logic                   is_residue;

   // Field trimming to the table and memory sizes
   assign addr_ext    = {{INDEX_BITS{1'b0}}, req_address};
   assign haddr_ext   = {{HIT_BITS{1'b0}}, req_address};
   assign data_ext    = {{HIT_BITS{1'b0}}, req_data};
   assign cell_addr   = addr_ext[INDEX_BITS-1:0];
   assign hit_wr_addr = haddr_ext[HIT_BITS-1:0];
   assign base_in     = data_ext[HIT_BITS-1:0];
   assign cnt_sat6    = (req_hit_count > 6'(MAX_WORD_HITS)) ? 6'(MAX_WORD_HITS)
                                                             : req_hit_count;
   assign cnt_sat     = cnt_sat6[CNT_BITS-1:0];

   // Rolling word index
   assign wl_eff    = (cfg.word_len == 3'd0) ? 3'd1 : cfg.word_len;
   assign wl_m1     = wl_eff - 3'd1;
   assign word_bits = 7'(wl_eff) * 7'(cfg.char_bits);
   always_comb begin
      for (int i = 0; i < INDEX_BITS; i++) begin
         idx_mask[i] = (7'(i) < word_bits);
      end
   end
   assign rolled = ({8'd0, idx_ff} << cfg.char_bits) | {{INDEX_BITS{1'b0}}, req_residue};
   assign idx_in = rolled[INDEX_BITS-1:0] & idx_mask;

   assign is_residue = (req_cmd == pwss_pkg::CMD_RESIDUE);

   // Cell tables: clearing sweep, cell writes, lookup
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         cell_counts[clr_ff] <= '0;
      end else if (cmd.accept && req_cmd == pwss_pkg::CMD_WRITE_CELL) begin
         cell_counts[cell_addr] <= cnt_sat;
      end
      if (cmd.accept && req_cmd == pwss_pkg::CMD_WRITE_CELL) begin
         cell_bases[cell_addr] <= base_in;
      end
      if (cmd.accept && is_residue) begin
         cnt_rd_ff  <= cell_counts[idx_in];
         base_rd_ff <= cell_bases[idx_in];
      end
   end

   // Hit memory
   assign hit_rd_addr = base_rd_ff + HIT_BITS'(walk_ff);
   always_ff @(posedge clock) begin
      if (cmd.accept && req_cmd == pwss_pkg::CMD_WRITE_HIT) begin
         hit_store[hit_wr_addr] <= req_data;
      end
      if (cmd.hit_rd) begin
         hit_rd_ff <= hit_store[hit_rd_addr];
      end
   end

   // Offsets for the result
   assign start    = pos_ff - 24'(wl_eff);
   assign back     = (letters_ff < wl_m1) ? letters_ff : wl_m1;
   assign done_off = pos_ff - 24'(back);
   assign room     = (cfg.capacity > hits_ff) ? (cfg.capacity - hits_ff) : 16'd0;

   // Scan state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         letters_ff   <= 3'd0;
         pos_ff       <= 24'd0;
         hits_ff      <= 16'd0;
         halted_ff    <= 1'b0;
         walk_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_wr) clr_ff <= clr_ff + 1'b1;
         if (cmd.accept) begin
            case (req_cmd)
               pwss_pkg::CMD_RESTART: begin
                  pos_ff     <= req_data;
                  idx_ff     <= '0;
                  letters_ff <= 3'd0;
                  hits_ff    <= 16'd0;
                  halted_ff  <= 1'b0;
               end
               pwss_pkg::CMD_RESIDUE: begin
                  if (!halted_ff) begin
                     idx_ff <= idx_in;
                     if (letters_ff < wl_eff) letters_ff <= letters_ff + 3'd1;
                     pos_ff <= pos_ff + 24'd1;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.walk_init) walk_ff <= '0;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
            if (cmd.kind == pwss_pkg::KIND_HIT) begin
               hits_ff <= hits_ff + 16'd1;
               walk_ff <= walk_ff + 1'b1;
            end else begin
               halted_ff <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.accept && is_residue) eos_ff <= req_end_of_sequence;
      if (cmd.load) begin
         rsp_kind_ff <= cmd.kind;
         rsp_last_ff <= cmd.last;
         case (cmd.kind)
            pwss_pkg::KIND_HIT: begin
               rsp_query_ff   <= hit_rd_ff;
               rsp_subject_ff <= start;
               rsp_total_ff   <= hits_ff + 16'd1;
            end
            pwss_pkg::KIND_STOP: begin
               rsp_query_ff   <= 24'd0;
               rsp_subject_ff <= start;
               rsp_total_ff   <= hits_ff;
            end
            default: begin
               rsp_query_ff   <= 24'd0;
               rsp_subject_ff <= done_off;
               rsp_total_ff   <= hits_ff;
            end
         endcase
      end
   end

   // Status to the controller
   assign status.residue_go = is_residue && !halted_ff;
   assign status.clear_done = &clr_ff;
   assign status.word_full  = (letters_ff >= wl_eff);
   assign status.cnt_zero   = (cnt_rd_ff == '0);
   assign status.fits       = (16'(cnt_rd_ff) <= room);
   assign status.walk_last  = ((walk_ff + 1'b1) == cnt_rd_ff);
   assign status.eos        = eos_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_query_offset   = rsp_query_ff;
   assign rsp_subject_offset = rsp_subject_ff;
   assign rsp_total_hits     = rsp_total_ff;
   assign rsp_last           = rsp_last_ff;
endmodule

// ===== hw/rtl/pwss_ctrl.sv =====
// Controller: sequences table clear, lookup, hit walk and result emission.
module pwss_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pwss_pkg::dp_status_type status,
   output pwss_pkg::dp_cmd_type    cmd
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.kind      = pwss_pkg::KIND_HIT;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.residue_go) state_in = ST_LOOK;
         end
         // cell data is back: decide between walk, stop, done or nothing
         ST_LOOK: begin
            if (status.word_full && !status.cnt_zero) begin
               if (status.fits) begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_RD;
               end else if (status.out_free) begin
                  cmd.load = 1'b1;
                  cmd.kind = pwss_pkg::KIND_STOP;
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (status.eos) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            cmd.hit_rd = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = pwss_pkg::KIND_HIT;
               cmd.last = status.walk_last && !status.eos;
               if (!status.walk_last) state_in = ST_RD;
               else if (status.eos)   state_in = ST_DONE;
               else                   state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = pwss_pkg::KIND_DONE;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end
endmodule

// ===== hw/rtl/protein_word_seed_scanner.sv =====
// Protein word seed scanner: residues roll into a word index, word hits are
// looked up and streamed out as (query offset, word start) pairs. After reset
// the block first clears the cell count table, one entry a cycle; no
// transaction is accepted during that pass. Table writes, restart and a
// residue while the scan is halted complete in the idle state. A residue is
// accepted while the cell table is read, then the controller decides; each
// emitted hit is a hit memory read, then a result register load, and a done
// result adds one more load; a stopped result is loaded in the deciding state.
// The hit walk through the single hit memory read port sets the rate on hitting
// words. The hit memory depth must be a power of two. A result waiting in the
// output register stalls the walk.
module protein_word_seed_scanner #(
   parameter int INDEX_BITS    = pwss_pkg::INDEX_BITS_DEF,
   parameter int HIT_DEPTH     = pwss_pkg::HIT_DEPTH_DEF,
   parameter int MAX_WORD_HITS = pwss_pkg::MAX_WORD_HITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pwss_req_if.sink    req_ch,
   pwss_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   pwss_pkg::cfg_type       cfg;
   pwss_pkg::dp_cmd_type    cmd;
   pwss_pkg::dp_status_type status;

   pwss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pwss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pwss_dp #(
      .INDEX_BITS    (INDEX_BITS),
      .HIT_DEPTH     (HIT_DEPTH),
      .MAX_WORD_HITS (MAX_WORD_HITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .status              (status),
      .req_cmd             (req_ch.cmd),
      .req_address         (req_ch.address),
      .req_hit_count       (req_ch.hit_count),
      .req_data            (req_ch.data),
      .req_residue         (req_ch.residue),
      .req_end_of_sequence (req_ch.end_of_sequence),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_kind            (rsp_ch.kind),
      .rsp_query_offset    (rsp_ch.query_offset),
      .rsp_subject_offset  (rsp_ch.subject_offset),
      .rsp_total_hits      (rsp_ch.total_hits),
      .rsp_last            (rsp_ch.last)
   );
endmodule

// ===== test/pwss_scoreboard.sv =====
// Scoreboard for the word seed scanner: predicts the result stream and checks it.
module pwss_scoreboard (
   input  logic        clock,
   input  logic        reset,
   pwss_req_if         req_mon,
   pwss_rsp_if         rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] query_offset;
      logic [23:0] subject_offset;
      logic [15:0] total_hits;
      logic        last;
   } result_type;

   // Shadow copy of the block's registers and tables
   logic [2:0]  word_len;
   logic [3:0]  res_bits;
   logic [15:0] cap;
   logic [5:0]  cell_cnt [0:32767];
   logic [15:0] cell_base [0:32767];
   logic [23:0] hit_mem [0:65535];
   logic [14:0] word_idx;
   int          seen;
   logic [23:0] pos;
   logic [15:0] hit_total;
   logic        halted;

   result_type  expected_q [$];

   task automatic push_result(input logic [1:0] kind, input logic [23:0] qo,
                              input logic [23:0] so);
      result_type r;
      r.kind = kind;
      r.query_offset = qo;
      r.subject_offset = so;
      r.total_hits = hit_total;
      r.last = 1'b0;
      expected_q.push_back(r);
   endtask

   // Advance the scanner model by one accepted transaction
   task automatic apply_command(input logic [1:0] cmd, input logic [15:0] addr,
                                input logic [5:0] cnt, input logic [23:0] data,
                                input logic [7:0] residue, input logic eos);
      int wl;
      int nbits;
      int mask;
      int n;
      int room;
      int first;
      logic [23:0] start;
      logic [23:0] back;
      logic [15:0] base;
      first = expected_q.size();
      case (cmd)
         pwss_pkg::CMD_WRITE_CELL: begin
            cell_cnt[addr[14:0]] = (cnt > 6'd32) ? 6'd32 : cnt;
            cell_base[addr[14:0]] = data[15:0];
         end
         pwss_pkg::CMD_WRITE_HIT: hit_mem[addr] = data;
         pwss_pkg::CMD_RESTART: begin
            pos = data;
            word_idx = '0;
            seen = 0;
            hit_total = '0;
            halted = 1'b0;
         end
         default: begin
            if (halted) return;
            wl = (word_len == 3'd0) ? 1 : int'(word_len);
            nbits = wl * int'(res_bits);
            if (nbits > 15) nbits = 15;
            mask = (1 << nbits) - 1;
            word_idx = 15'(((int'(word_idx) << res_bits) | int'(residue)) & mask);
            if (seen < wl) seen++;
            pos = pos + 24'd1;
            if (seen >= wl) begin
               n = int'(cell_cnt[word_idx]);
               start = pos - 24'(wl);
               if (n != 0) begin
                  room = (int'(cap) > int'(hit_total)) ? int'(cap) - int'(hit_total) : 0;
                  if (n <= room) begin
                     base = cell_base[word_idx];
                     for (int i = 0; i < n; i++) begin
                        hit_total++;
                        push_result(pwss_pkg::KIND_HIT, hit_mem[16'(base + 16'(i))],
                                    start);
                     end
                  end else begin
                     // Not enough room left: stop and hold until restart
                     push_result(pwss_pkg::KIND_STOP, '0, start);
                     halted = 1'b1;
                     expected_q[expected_q.size() - 1].last = 1'b1;
                     return;
                  end
               end
            end
            if (eos) begin
               back = (seen < wl - 1) ? 24'(seen) : 24'(wl - 1);
               push_result(pwss_pkg::KIND_DONE, '0, pos - back);
               halted = 1'b1;
            end
            if (expected_q.size() > first)
               expected_q[expected_q.size() - 1].last = 1'b1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         word_len = pwss_pkg::WORD_LEN_RST;
         res_bits = pwss_pkg::CHAR_BITS_RST;
         cap = pwss_pkg::CAPACITY_RST;
         foreach (cell_cnt[i]) cell_cnt[i] = '0;
         word_idx = '0;
         seen = 0;
         pos = '0;
         hit_total = '0;
         halted = 1'b0;
         expected_q.delete();
         fail_count <= 0;
         checked <= 0;
      end else begin
         // Register writes on the config port
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               pwss_pkg::REG_WORD_LEN:  word_len = csr_pwdata[2:0];
               pwss_pkg::REG_CHAR_BITS: res_bits = csr_pwdata[3:0];
               pwss_pkg::REG_CAPACITY:  cap = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            apply_command(req_mon.cmd, req_mon.address, req_mon.hit_count, req_mon.data,
                          req_mon.residue, req_mon.end_of_sequence);
         // Compare each result transaction with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.kind, rsp_mon.query_offset, rsp_mon.subject_offset,
                   rsp_mon.total_hits, rsp_mon.last};
            checked <= checked + 1;
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected result kind=%0d q=%h s=%h total=%0d last=%b",
                           got.kind, got.query_offset, got.subject_offset,
                           got.total_hits, got.last);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("ERROR: result exp kind=%0d q=%h s=%h total=%0d last=%b,",
                              want.kind, want.query_offset, want.subject_offset,
                              want.total_hits, want.last);
                     $display("       got kind=%0d q=%h s=%h total=%0d last=%b",
                              got.kind, got.query_offset, got.subject_offset,
                              got.total_hits, got.last);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

// ===== test/protein_word_seed_scanner_test.sv =====
// Testbench top for the word seed scanner: stimulus, config writes and verdict.
module protein_word_seed_scanner_test;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          checked;
   int          cycles;
   int          sent;
   int          phases;
   logic        calm;
   bit          hit_known [0:65535];
   int          cur_wl;
   int          cur_cb;

   pwss_req_if req_ch ();
   pwss_rsp_if rsp_ch ();

   protein_word_seed_scanner i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pwss_scoreboard i_scoreboard (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side back-pressure
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // One command transaction, called at a falling edge
   task automatic send(input logic [1:0] cmd, input logic [15:0] addr,
                       input logic [5:0] cnt, input logic [23:0] data,
                       input logic [7:0] residue, input logic eos);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.cmd = cmd;
      req_ch.address = addr;
      req_ch.hit_count = cnt;
      req_ch.data = data;
      req_ch.residue = residue;
      req_ch.end_of_sequence = eos;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 1'b0;
      sent++;
   endtask

   task automatic write_hit(input logic [15:0] addr, input logic [23:0] data);
      send(pwss_pkg::CMD_WRITE_HIT, addr, 6'($urandom), data, 8'($urandom),
           1'($urandom));
      hit_known[addr] = 1'b1;
   endtask

   // Cell write; fills any hit words its list would read that are still unwritten
   task automatic write_cell(input logic [15:0] addr, input logic [5:0] cnt,
                             input logic [23:0] data);
      int eff;
      logic [15:0] a;
      eff = (cnt > 6'd32) ? 32 : int'(cnt);
      for (int i = 0; i < eff; i++) begin
         a = data[15:0] + 16'(i);
         if (!hit_known[a]) write_hit(a, 24'($urandom));
      end
      send(pwss_pkg::CMD_WRITE_CELL, addr, cnt, data, 8'($urandom), 1'($urandom));
   endtask

   task automatic residue(input logic [7:0] r, input logic eos);
      send(pwss_pkg::CMD_RESIDUE, 16'($urandom), 6'($urandom), 24'($urandom), r, eos);
   endtask

   task automatic restart(input logic [23:0] start);
      send(pwss_pkg::CMD_RESTART, 16'($urandom), 6'($urandom), start, 8'($urandom),
           1'($urandom));
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Let outstanding results drain, then give a silent residue time to finish
   task automatic wait_idle();
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   initial begin
      int wl_tab [8];
      int cb_tab [8];
      int cap_tab [8];
      int p;
      int wl;
      int nbits;
      int nres;
      int space;
      int ncells;
      int r;
      logic [5:0] cnt;
      logic [7:0] rv;
      logic [23:0] start;

      wl_tab = '{2, 1, 3, 0, 6, 4, 5, 2};
      cb_tab = '{2, 4, 1, 3, 8, 2, 1, 3};
      cap_tab = '{65535, 20, 7, 1, 65535, 40, 3, 100};
      sent = 0;
      phases = 0;
      calm = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = pwss_pkg::CMD_WRITE_CELL;
      req_ch.address = '0;
      req_ch.hit_count = '0;
      req_ch.data = '0;
      req_ch.residue = '0;
      req_ch.end_of_sequence = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: reset config, saturated count, hit list wrapping the memory end
      write_hit(16'hFFFF, 24'hFFFFFF);
      write_hit(16'h0000, 24'h000000);
      write_cell(16'hFFFF, 6'd2, 24'hFFFFFF);
      write_cell(16'h0000, 6'd63, 24'h000064);
      restart(24'hFFFFFE);
      residue(8'd0, 1'b0);
      residue(8'd0, 1'b0);
      residue(8'd0, 1'b0);
      residue(8'd31, 1'b0);
      residue(8'd31, 1'b0);
      residue(8'd31, 1'b0);
      residue(8'hFF, 1'b1);
      residue(8'd0, 1'b1);
      restart(24'h000000);
      residue(8'hFF, 1'b1);
      wait_idle();

      // Random phases, each with its own register setting
      while (sent < 205) begin
         p = phases % 8;
         phases++;
         calm = (phases % 3 == 2);
         csr_write(pwss_pkg::REG_WORD_LEN, 32'(wl_tab[p]));
         csr_write(pwss_pkg::REG_CHAR_BITS, 32'(cb_tab[p]));
         csr_write(pwss_pkg::REG_CAPACITY, 32'(cap_tab[p]));
         cur_wl = wl_tab[p];
         cur_cb = cb_tab[p];
         wl = (cur_wl == 0) ? 1 : cur_wl;
         nbits = (wl * cur_cb > 15) ? 15 : wl * cur_cb;
         space = 1 << nbits;
         ncells = (space < 8) ? space : $urandom_range(4, 8);
         for (int k = 0; k < ncells; k++) begin
            r = $urandom_range(0, 9);
            cnt = (r == 0) ? 6'd0 : (r == 1) ? 6'($urandom_range(20, 63))
                                             : 6'($urandom_range(1, 4));
            write_cell({1'($urandom), 15'($urandom_range(0, space - 1))}, cnt,
                       {8'($urandom),
                        ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 255))});
         end
         // Scans of residue runs, mostly in range, occasionally without restart
         for (int s = 0; s < 3; s++) begin
            if ($urandom_range(0, 4) != 0) begin
               r = $urandom_range(0, 3);
               start = (r == 0) ? 24'hFFFFFF - 24'($urandom_range(0, 8))
                                : (r == 1) ? 24'h0 : 24'($urandom);
               restart(start);
            end
            nres = $urandom_range(1, 12);
            for (int i = 0; i < nres; i++) begin
               rv = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, (1 << cur_cb) - 1));
               residue(rv, (i == nres - 1) && ($urandom_range(0, 4) != 0));
            end
            if ($urandom_range(0, 3) == 0) residue(8'($urandom), 1'($urandom));
         end
         wait_idle();
      end

      calm = 1'b1;
      wait_idle();
      repeat (20) @(negedge clock);
      $display("Sent %0d command transactions over %0d register settings;", sent, phases);
      $display("checked %0d result transactions, %0d mismatches.", checked, fail_count);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
